>>> src/bdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bdn_pkg;

  localparam int MAX_SOURCE_WIDTH = 4096;
  localparam int MAX_OUTPUT_WIDTH = 4096;
  localparam int COL_W = $clog2(MAX_SOURCE_WIDTH);
  localparam int OX_W = $clog2(MAX_OUTPUT_WIDTH);
  localparam int OY_W = 13;
  localparam int CI_W = OX_W - 1;
  localparam int ROW_W = 16;
  localparam logic [ROW_W-1:0] ROW_CAP = 16'hFFFF;
  localparam int ADDR_W = 25;
  localparam int CFG_DATA_W = 14;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] COEF_YR = 8'd77;
  localparam logic [7:0] COEF_YG = 8'd150;
  localparam logic [7:0] COEF_YB = 8'd29;
  localparam logic [7:0] COEF_UR = 8'd43;
  localparam logic [7:0] COEF_UG = 8'd85;
  localparam logic [7:0] COEF_VG = 8'd107;
  localparam logic [7:0] COEF_VB = 8'd21;
  localparam logic [7:0] HALF = 8'd128;

  typedef enum logic [2:0] {
    REG_STRIDE   = 3'd0,
    REG_SRC_W    = 3'd1,
    REG_CROP_L   = 3'd2,
    REG_CROP_T   = 3'd3,
    REG_OUT_W    = 3'd4,
    REG_OUT_H    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [13:0] stride;
    logic [12:0] src_w;
    logic [11:0] crop_l;
    logic [11:0] crop_t;
    logic [12:0] out_w;
    logic [12:0] out_h;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       val;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pix_t;

endpackage
`default_nettype wire

>>> src/bayer_demosaic_to_nv12.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | ports                                          | accepted when
// input   | in_valid, in_stall, in_raw_byte, in_first_of_frame | in_valid && !in_stall
// result  | out_valid, out_stall, out_address, out_value,   | out_valid && !out_stall
//         | out_last_in_run                                |
// config  | cfg_we, cfg_index, cfg_data                    | cfg_we
// One raw byte per cycle is taken while the 4-entry pixel queue has room.
// A pixel moves from the queue through S1, S2, S3, S4 and the result register;
// the single result port emits one byte per cycle while out_stall is low, so a
// pixel with chroma holds the back pipeline for Y, U and V, a luma-only one for Y.
// Synchronous reset clears counters, queue, window and valid flags; the line
// and chroma stores are not cleared. out_stall freezes the whole back part while out_valid is high.
module bayer_demosaic_to_nv12 (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_raw_byte,
  input  wire logic                            in_first_of_frame,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bdn_pkg::ADDR_W-1:0]           out_address,
  output logic [7:0]                           out_value,
  output logic                                 out_last_in_run,
  input  wire logic                            cfg_we,
  input  wire logic [2:0]                      cfg_index,
  input  wire logic [bdn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bdn_pkg::cfg_t cfg_r;
  bdn_pkg::pix_t px, head;
  logic px_push, q_empty, q_full, pop, take;

  // hold configuration registers; writes only while idle, which the user must keep; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stride <= 14'd5104;
      cfg_r.src_w  <= 13'd4076;
      cfg_r.crop_l <= 12'd118;
      cfg_r.crop_t <= 12'd322;
      cfg_r.out_w  <= 13'd3840;
      cfg_r.out_h  <= 13'd2160;
    end else if (cfg_we) begin
      case (cfg_index)
        bdn_pkg::REG_STRIDE: cfg_r.stride <= cfg_data;
        bdn_pkg::REG_SRC_W:  cfg_r.src_w  <= cfg_data[12:0];
        bdn_pkg::REG_CROP_L: cfg_r.crop_l <= cfg_data[11:0];
        bdn_pkg::REG_CROP_T: cfg_r.crop_t <= cfg_data[11:0];
        bdn_pkg::REG_OUT_W:  cfg_r.out_w  <= cfg_data[12:0];
        bdn_pkg::REG_OUT_H:  cfg_r.out_h  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // stall input only when the queue is full
  assign in_stall = q_full;
  assign take = in_valid && !q_full;

  bdn_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .take(take),
    .raw_byte(in_raw_byte), .first(in_first_of_frame),
    .px(px), .px_push(px_push)
  );

  bdn_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(px_push), .wdata(px), .pop(pop),
    .rdata(head), .empty(q_empty), .full(q_full)
  );

  bdn_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .head_v(!q_empty),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_address(out_address), .out_value(out_value),
    .out_last_in_run(out_last_in_run)
  );

endmodule
`default_nettype wire

>>> src/bdn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bdn_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bdn_pkg::cfg_t  cfg,
  input  wire logic           take,
  input  wire logic [7:0]     raw_byte,
  input  wire logic           first,
  output bdn_pkg::pix_t       px,
  output logic                px_push
);

  logic [13:0] byte_r, byte_nxt, byte_e;
  logic [2:0]  off_r, off_nxt, off_e;
  logic [13:0] base_r, base_nxt, base_e;
  logic [bdn_pkg::ROW_W-1:0] row_r, row_nxt, row_e;
  logic [13:0] col;
  logic [12:0] sw;
  logic [14:0] byte_inc;

  always_comb begin
    byte_e = first ? 14'd0 : byte_r;
    off_e  = first ? 3'd0 : off_r;
    base_e = first ? 14'd0 : base_r;
    row_e  = first ? '0 : row_r;
    sw = (cfg.src_w < 13'(bdn_pkg::MAX_SOURCE_WIDTH)) ? cfg.src_w
                                                    : 13'(bdn_pkg::MAX_SOURCE_WIDTH);
    col = base_e + {11'd0, off_e};
    byte_inc = {1'b0, byte_e} + 15'd1;
    px_push = take && (off_e < 3'd4) && (col < {1'b0, sw});
    px.val = raw_byte;
    px.row = row_e;
    px.col = col[bdn_pkg::COL_W-1:0];
    if (byte_inc >= {1'b0, cfg.stride}) begin
      byte_nxt = 14'd0;
      off_nxt  = 3'd0;
      base_nxt = 14'd0;
      row_nxt  = (row_e < bdn_pkg::ROW_CAP) ? row_e + 1'b1 : row_e;
    end else begin
      byte_nxt = byte_inc[13:0];
      off_nxt  = (off_e == 3'd4) ? 3'd0 : off_e + 3'd1;
      base_nxt = (off_e == 3'd4) ? base_e + 14'd4 : base_e;
      row_nxt  = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      off_r  <= '0;
      base_r <= '0;
      row_r  <= '0;
    end else if (take) begin
      byte_r <= byte_nxt;
      off_r  <= off_nxt;
      base_r <= base_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/bdn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bdn_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bdn_pkg::pix_t wdata,
  input  wire logic          pop,
  output bdn_pkg::pix_t      rdata,
  output logic               empty,
  output logic               full
);

  localparam int PW = $clog2(bdn_pkg::QUEUE_DEPTH);

  bdn_pkg::pix_t mem [bdn_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(bdn_pkg::QUEUE_DEPTH));
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> src/bdn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bdn_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bdn_pkg::cfg_t               cfg,
  input  wire bdn_pkg::pix_t               head,
  input  wire logic                        head_v,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bdn_pkg::ADDR_W-1:0]       out_address,
  output logic [7:0]                       out_value,
  output logic                             out_last_in_run
);

  localparam int CW = bdn_pkg::COL_W;
  localparam int OW = bdn_pkg::OX_W;
  localparam int YW = bdn_pkg::OY_W;
  localparam int CIW = bdn_pkg::CI_W;
  localparam int AW = bdn_pkg::ADDR_W;

  function automatic logic [15:0] COEF(input logic [7:0] a, input logic [7:0] c);
    return 16'(a) * 16'(c);
  endfunction

  logic adv;

  // line stores
  logic [7:0] line_a [bdn_pkg::MAX_SOURCE_WIDTH];
  logic [7:0] line_b [bdn_pkg::MAX_SOURCE_WIDTH];
  logic       s1_v_r;
  bdn_pkg::pix_t s1_r;
  logic [7:0] rd_a_r, rd_b_r;
  logic       byp;

  assign pop = adv && head_v;
  assign byp = s1_v_r && (s1_r.col == head.col);

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_a_r <= byp ? s1_r.val : line_a[head.col];
      rd_b_r <= byp ? rd_a_r : line_b[head.col];
      s1_r   <= head;
    end
    if (adv && s1_v_r) begin
      line_a[s1_r.col] <= s1_r.val;
      line_b[s1_r.col] <= rd_a_r;
    end
  end

  // window, S2
  logic [7:0] n_r [3][3];
  logic       s2_v_r;
  logic [bdn_pkg::ROW_W-1:0] s2_row_r;
  logic [CW-1:0] s2_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) n_r[i][j] <= '0;
    end else if (adv && s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i][0] <= n_r[i][1];
        n_r[i][1] <= n_r[i][2];
      end
      n_r[0][2] <= rd_b_r;
      n_r[1][2] <= rd_a_r;
      n_r[2][2] <= s1_r.val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_r <= s1_r.row;
      s2_col_r <= s1_r.col;
    end
  end

  // S2: window check and bilinear RGB
  logic [12:0] w_lim;
  logic [bdn_pkg::ROW_W-1:0] cy, oy_f;
  logic [CW-1:0] cx, ox_f;
  logic ok2;
  logic [7:0] r2, g2, b2;
  logic [9:0] s4a, s4b;
  logic [8:0] s2a, s2b, s2c, s2d;

  always_comb begin
    w_lim = (cfg.out_w < 13'(bdn_pkg::MAX_OUTPUT_WIDTH)) ? cfg.out_w
                                                       : 13'(bdn_pkg::MAX_OUTPUT_WIDTH);
    cy = s2_row_r - 1'b1;
    cx = s2_col_r - 1'b1;
    oy_f = cy - {{(bdn_pkg::ROW_W-12){1'b0}}, cfg.crop_t};
    ox_f = cx - CW'(cfg.crop_l);
    ok2 = s2_v_r && (s2_row_r >= 2) && (s2_col_r >= 2) && (s2_row_r != bdn_pkg::ROW_CAP)
          && (cy >= {{(bdn_pkg::ROW_W-12){1'b0}}, cfg.crop_t})
          && ({1'b0, cx} >= (CW+1)'(cfg.crop_l))
          && (oy_f < {{(bdn_pkg::ROW_W-13){1'b0}}, cfg.out_h})
          && ({1'b0, ox_f} < (CW+1)'(w_lim));
    s4a = 10'(n_r[1][0]) + 10'(n_r[1][2]) + 10'(n_r[0][1]) + 10'(n_r[2][1]) + 10'd2;
    s4b = 10'(n_r[0][0]) + 10'(n_r[0][2]) + 10'(n_r[2][0]) + 10'(n_r[2][2]) + 10'd2;
    s2a = 9'(n_r[1][0]) + 9'(n_r[1][2]) + 9'd1;
    s2b = 9'(n_r[0][1]) + 9'(n_r[2][1]) + 9'd1;
    s2c = s2a;
    s2d = s2b;
    case ({cy[0], cx[0]})
      2'b01: begin
        r2 = n_r[1][1]; g2 = s4a[9:2]; b2 = s4b[9:2];
      end
      2'b10: begin
        b2 = n_r[1][1]; g2 = s4a[9:2]; r2 = s4b[9:2];
      end
      2'b00: begin
        g2 = n_r[1][1]; r2 = s2a[8:1]; b2 = s2b[8:1];
      end
      default: begin
        g2 = n_r[1][1]; r2 = s2d[8:1]; b2 = s2c[8:1];
      end
    endcase
  end

  // S3
  logic s3_v_r;
  logic [7:0] r3_r, g3_r, b3_r;
  logic [YW-1:0] oy3_r;
  logic [OW-1:0] ox3_r;
  logic [26:0] csum [bdn_pkg::MAX_OUTPUT_WIDTH/2];
  logic [26:0] e_r;
  logic [CIW-1:0] ci2, ci3;
  logic [8:0] pr_r, pg_r, pb_r;
  logic cs_we;
  logic [9:0] fr3, fg3, fb3;
  logic [26:0] cs_wd;

  assign ci2 = ox_f[CIW:1];
  assign ci3 = ox3_r[CIW:1];

  // even output rows: store the left pixel, add the right one onto the entry
  always_comb begin
    fr3 = 10'(e_r[8:0]) + 10'(r3_r);
    fg3 = 10'(e_r[17:9]) + 10'(g3_r);
    fb3 = 10'(e_r[26:18]) + 10'(b3_r);
    cs_we = s3_v_r && !oy3_r[0];
    if (ox3_r[0])
      cs_wd = 27'({fb3, 18'd0}) | 27'({fg3, 9'd0}) | 27'(fr3);
    else
      cs_wd = {1'b0, b3_r, 1'b0, g3_r, 1'b0, r3_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_r  <= r2;
      g3_r  <= g2;
      b3_r  <= b2;
      oy3_r <= oy_f[YW-1:0];
      ox3_r <= ox_f[OW-1:0];
      // forward the entry being written this edge
      e_r   <= (cs_we && (ci3 == ci2)) ? cs_wd : csum[ci2];
    end
    if (adv && cs_we)
      csum[ci3] <= cs_wd;
  end

  // hold the left pixel of an odd output row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_r <= '0;
      pg_r <= '0;
      pb_r <= '0;
    end else if (adv && s3_v_r && oy3_r[0] && !ox3_r[0]) begin
      pr_r <= 9'(r3_r);
      pg_r <= 9'(g3_r);
      pb_r <= 9'(b3_r);
    end
  end

  logic [16:0] ysum;
  logic [10:0] mr3, mg3, mb3;
  logic [AW-1:0] laddr3;
  logic [24:0] prod3;

  always_comb begin
    ysum = 17'(COEF(r3_r, bdn_pkg::COEF_YR)) + 17'(COEF(g3_r, bdn_pkg::COEF_YG))
         + 17'(COEF(b3_r, bdn_pkg::COEF_YB)) + 17'(bdn_pkg::HALF);
    mr3 = 11'(e_r[8:0]) + 11'(pr_r) + 11'(r3_r) + 11'd2;
    mg3 = 11'(e_r[17:9]) + 11'(pg_r) + 11'(g3_r) + 11'd2;
    mb3 = 11'(e_r[26:18]) + 11'(pb_r) + 11'(b3_r) + 11'd2;
    prod3 = 25'(oy3_r) * 25'(w_lim);
    laddr3 = prod3 + AW'(ox3_r);
  end

  // S4
  logic s4_v_r, c4_r;
  logic [7:0] y4_r, mr4_r, mg4_r, mb4_r;
  logic [AW-1:0] laddr4_r;
  logic [YW-2:0] oyh4_r;
  logic [OW-1:0] ox4_r;
  logic [AW-1:0] wh_r;

  always_ff @(posedge clk) begin
    wh_r <= AW'(26'(cfg.out_h) * 26'(w_lim));
    if (adv) begin
      y4_r     <= ysum[15:8];
      mr4_r    <= mr3[9:2];
      mg4_r    <= mg3[9:2];
      mb4_r    <= mb3[9:2];
      laddr4_r <= laddr3;
      oyh4_r   <= oy3_r[YW-1:1];
      ox4_r    <= ox3_r;
      c4_r     <= oy3_r[0] && ox3_r[0];
    end
  end

  logic signed [19:0] er, eg, eb, su, sv, tu, tv;
  logic [7:0] u4, v4;
  logic [AW-1:0] caddr4;

  always_comb begin
    er = 20'(mr4_r);
    eg = 20'(mg4_r);
    eb = 20'(mb4_r);
    su = (eb <<< 7) - er * 20'sd43 - eg * 20'sd85 + 20'sd128;
    sv = (er <<< 7) - eg * 20'sd107 - eb * 20'sd21 + 20'sd128;
    tu = 20'sd128 + (su >>> 8);
    tv = 20'sd128 + (sv >>> 8);
    u4 = (tu < 0) ? 8'd0 : ((tu > 20'sd255) ? 8'd255 : tu[7:0]);
    v4 = (tv < 0) ? 8'd0 : ((tv > 20'sd255) ? 8'd255 : tv[7:0]);
    caddr4 = wh_r + AW'(24'(oyh4_r) * 24'(w_lim)) + AW'(ox4_r) - AW'(1);
  end

  // result emitter
  logic em_v_r, em_c_r;
  logic [1:0] idx_r;
  logic [7:0] em_y_r, em_u_r, em_v_val_r;
  logic [AW-1:0] em_la_r, em_ca_r;
  logic take, last;

  assign out_valid = em_v_r;
  assign last = em_c_r ? (idx_r == 2'd2) : (idx_r == 2'd0);
  assign take = em_v_r && !out_stall;
  assign adv = !em_v_r || (take && last);
  assign out_last_in_run = last;

  always_comb begin
    case (idx_r)
      2'd0: begin out_address = em_la_r; out_value = em_y_r; end
      2'd1: begin out_address = em_ca_r; out_value = em_u_r; end
      default: begin out_address = em_ca_r + AW'(1); out_value = em_v_val_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      em_y_r     <= y4_r;
      em_u_r     <= u4;
      em_v_val_r <= v4;
      em_la_r    <= laddr4_r;
      em_ca_r    <= caddr4;
      em_c_r     <= c4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      em_v_r <= 1'b0;
      idx_r  <= '0;
    end else if (adv) begin
      s1_v_r <= head_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= ok2;
      s4_v_r <= s3_v_r;
      em_v_r <= s4_v_r;
      idx_r  <= '0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire
